FILE: design/cst_pkg.sv
// shared types and constants of the character stream tokenizer
`timescale 1ns / 1ps

package cst_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT   = 8;
   localparam int KIND_BITS             = 4;
   localparam int CHAR_BITS             = 8;
   localparam int QUEUE_DEPTH           = 4;

   localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_CARET      = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_LESS       = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_LESS_EQ    = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_GREATER    = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_GREATER_EQ = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_PLUS       = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_MINUS      = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_CONST      = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_IDENT      = 4'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_LESS    = 8'h3C;
   localparam logic [CHAR_BITS-1:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CHAR_GREATER = 8'h3E;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_CARET   = 8'h5E;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CHAR_RBRACE  = 8'h7D;

   // which of the two token slots a byte fills
   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } push_type;

endpackage

FILE: design/char_stream_tokenizer.sv
// top level of the character stream tokenizer
`timescale 1ns / 1ps

// Takes one source byte per transfer and emits tokens (kind, start line, start
// column, length) on the result stream, tlast marking the last token a byte
// caused. A byte is scanned in the cycle it is taken: position counters and
// the run state update at that edge and its tokens enter a four-entry token
// queue, which drains one token per cycle while the receiver is ready. A new
// byte is taken every cycle while the queue holds at most two tokens, so the
// sustained rate, with the receiver ready, is one byte per cycle when each
// byte causes at most one token, and set by the one-token-per-cycle drain
// otherwise. A byte's first token is visible the cycle after it is taken
// when the queue was empty. After the byte marked with tlast the pending
// token is flushed and line and column keep counting.

module char_stream_tokenizer #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEFAULT,
   parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEFAULT,
   localparam int TOK_W   = cst_pkg::KIND_BITS + 2 * POSITION_BITS + LENGTH_BITS + 1,
   localparam int TDATA_W = ((TOK_W - 1 + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // char_byte
   input  logic               req_tlast,   // final_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // token_kind, token_line, token_column, token_length
   output logic               rsp_tlast    // last_of_run
);

   cst_pkg::push_type push;
   logic [TOK_W-1:0]  first_tok, second_tok, out_tok;
   logic              accept;

   assign accept = req_tvalid && req_tready;

   cst_scanner #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_tdata),
      .final_byte (req_tlast),
      .push       (push),
      .first_tok  (first_tok),
      .second_tok (second_tok)
   );

   cst_token_queue #(
      .TOK_W (TOK_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_tok  (first_tok),
      .second_tok (second_tok),
      .room       (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tok    (out_tok)
   );

   assign rsp_tdata = TDATA_W'(out_tok[TOK_W-2:0]);
   assign rsp_tlast = out_tok[TOK_W-1];

endmodule

FILE: design/cst_scanner.sv
// scan state, position counters and token forming for one byte per cycle while bytes are accepted
`timescale 1ns / 1ps

module cst_scanner #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEFAULT,
   parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEFAULT,
   localparam int TOK_W = cst_pkg::KIND_BITS + 2 * POSITION_BITS + LENGTH_BITS + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [cst_pkg::CHAR_BITS-1:0]  char_byte,
   input  logic                           final_byte,
   output cst_pkg::push_type              push,
   output logic [TOK_W-1:0]               first_tok,
   output logic [TOK_W-1:0]               second_tok
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_LESS    = 3'd1;
   localparam logic [2:0] MODE_GREATER = 3'd2;
   localparam logic [2:0] MODE_CONST   = 3'd3;
   localparam logic [2:0] MODE_IDENT   = 3'd4;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
   localparam logic [LENGTH_BITS-1:0]   LEN_TWO = LENGTH_BITS'(2);

   logic [2:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   logic [POSITION_BITS-1:0] sline_ff, sline_in, scol_ff, scol_in;
   logic [LENGTH_BITS-1:0]   run_ff, run_in;

   logic                          is_digit, is_letter, is_eq;
   logic                          t0_valid, consumed, extend;
   logic [cst_pkg::KIND_BITS-1:0] t0_kind;
   logic [LENGTH_BITS-1:0]        t0_len;
   logic                          s_valid, new_run;
   logic [cst_pkg::KIND_BITS-1:0] s_kind;
   logic [2:0]                    new_mode;
   logic                          f_valid;
   logic [cst_pkg::KIND_BITS-1:0] f_kind;
   logic [TOK_W-1:0]              t0_tok, t1_tok;
   logic                          t1_valid;

   function automatic logic [TOK_W-1:0] pack_tok(
      input logic [cst_pkg::KIND_BITS-1:0] kind,
      input logic [POSITION_BITS-1:0]      line,
      input logic [POSITION_BITS-1:0]      col,
      input logic [LENGTH_BITS-1:0]        len,
      input logic                          last
   );
      return {last, len, col, line, kind};
   endfunction

   assign is_digit  = (char_byte >= cst_pkg::CHAR_DIGIT_0) && (char_byte <= cst_pkg::CHAR_DIGIT_9);
   assign is_letter = ((char_byte >= cst_pkg::CHAR_UPPER_A) && (char_byte <= cst_pkg::CHAR_UPPER_Z))
                   || ((char_byte >= cst_pkg::CHAR_LOWER_A) && (char_byte <= cst_pkg::CHAR_LOWER_Z));
   assign is_eq     = (char_byte == cst_pkg::CHAR_EQUAL);

   // token closed by the pending state
   always_comb begin
      t0_valid = 1'b0;
      t0_kind  = cst_pkg::KIND_LESS;
      t0_len   = run_ff;
      extend   = 1'b0;
      consumed = 1'b0;
      unique case (mode_ff) inside
         MODE_LESS, MODE_GREATER: begin
            t0_valid = 1'b1;
            if (is_eq) begin
               consumed = 1'b1;
               t0_len   = LEN_TWO;
               t0_kind  = (mode_ff == MODE_LESS) ? cst_pkg::KIND_LESS_EQ
                                                 : cst_pkg::KIND_GREATER_EQ;
            end else begin
               t0_kind  = (mode_ff == MODE_LESS) ? cst_pkg::KIND_LESS
                                                 : cst_pkg::KIND_GREATER;
            end
         end
         MODE_CONST: begin
            extend   = is_digit;
            consumed = is_digit;
            t0_valid = !is_digit;
            t0_kind  = cst_pkg::KIND_CONST;
         end
         MODE_IDENT: begin
            extend   = is_digit || is_letter;
            consumed = is_digit || is_letter;
            t0_valid = !(is_digit || is_letter);
            t0_kind  = cst_pkg::KIND_IDENT;
         end
         default: ;
      endcase
   end

   // the byte taken fresh
   always_comb begin
      s_valid  = 1'b0;
      s_kind   = cst_pkg::KIND_LBRACE;
      new_run  = 1'b0;
      new_mode = MODE_IDLE;
      if (!consumed) begin
         case (char_byte)
            cst_pkg::CHAR_LBRACE: begin s_valid = 1'b1; s_kind = cst_pkg::KIND_LBRACE; end
            cst_pkg::CHAR_RBRACE: begin s_valid = 1'b1; s_kind = cst_pkg::KIND_RBRACE; end
            cst_pkg::CHAR_CARET:  begin s_valid = 1'b1; s_kind = cst_pkg::KIND_CARET; end
            cst_pkg::CHAR_PLUS:   begin s_valid = 1'b1; s_kind = cst_pkg::KIND_PLUS; end
            cst_pkg::CHAR_MINUS:  begin s_valid = 1'b1; s_kind = cst_pkg::KIND_MINUS; end
            cst_pkg::CHAR_LESS:   begin new_run = 1'b1; new_mode = MODE_LESS; end
            cst_pkg::CHAR_GREATER: begin new_run = 1'b1; new_mode = MODE_GREATER; end
            default: begin
               if (is_digit) begin
                  new_run  = 1'b1;
                  new_mode = MODE_CONST;
               end else if (is_letter) begin
                  new_run  = 1'b1;
                  new_mode = MODE_IDENT;
               end
            end
         endcase
      end
   end

   // run state after this byte, before the end-of-source flush
   always_comb begin
      mode_in  = MODE_IDLE;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      run_in   = run_ff;
      if (extend) begin
         mode_in = mode_ff;
         if (run_ff != LEN_MAX) begin
            run_in = run_ff + LEN_ONE;
         end
      end else if (new_run) begin
         mode_in  = new_mode;
         sline_in = line_ff;
         scol_in  = col_ff;
         run_in   = LEN_ONE;
      end
   end

   always_comb begin
      f_valid = final_byte && (mode_in != MODE_IDLE);
      unique case (mode_in)
         MODE_LESS:    f_kind = cst_pkg::KIND_LESS;
         MODE_GREATER: f_kind = cst_pkg::KIND_GREATER;
         MODE_CONST:   f_kind = cst_pkg::KIND_CONST;
         default:      f_kind = cst_pkg::KIND_IDENT;
      endcase
   end

   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (char_byte == cst_pkg::CHAR_NEWLINE) begin
         if (line_ff != POS_MAX) begin
            line_in = line_ff + POS_ONE;
         end
         col_in = POS_ONE;
      end else if (col_ff != POS_MAX) begin
         col_in = col_ff + POS_ONE;
      end
   end

   // a fresh single-character token and the flush never meet
   assign t1_valid = s_valid || f_valid;
   assign t0_tok   = pack_tok(t0_kind, sline_ff, scol_ff, t0_len, !t1_valid);
   assign t1_tok   = s_valid ? pack_tok(s_kind, line_ff, col_ff, LEN_ONE, 1'b1)
                             : pack_tok(f_kind, sline_in, scol_in, run_in, 1'b1);

   // tokens enter the queue only on a byte transfer
   assign push.first_valid  = accept && (t0_valid || t1_valid);
   assign push.second_valid = accept && t0_valid && t1_valid;
   assign first_tok         = t0_valid ? t0_tok : t1_tok;
   assign second_tok        = t1_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         sline_ff <= '0;
         scol_ff  <= '0;
         run_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= final_byte ? MODE_IDLE : mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         run_ff   <= run_in;
      end
   end

endmodule

FILE: design/cst_token_queue.sv
// small token queue that takes up to two tokens and gives one per cycle while the reader is ready
`timescale 1ns / 1ps

module cst_token_queue #(
   parameter int TOK_W = 45
) (
   input  logic              clock,
   input  logic              reset,
   input  cst_pkg::push_type push,
   input  logic [TOK_W-1:0]  first_tok,
   input  logic [TOK_W-1:0]  second_tok,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [TOK_W-1:0]  out_tok
);

   localparam int DEPTH = cst_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [TOK_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [CNT_W-1:0] push_n;

   assign out_valid = (cnt_ff != '0);
   assign out_tok   = entry_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // room for the two tokens one byte can cause
   assign room      = (cnt_ff <= CNT_W'(DEPTH - 2));
   assign push_n    = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);

   assign wr_in  = wr_ff + PTR_W'(push_n);
   assign rd_in  = rd_ff + PTR_W'(pop);
   assign cnt_in = cnt_ff + push_n - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ff] <= first_tok;
      end
      if (push.second_valid) begin
         entry_ff[wr_ff + PTR_W'(1)] <= second_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: design/cst_checker.sv
// port-level checks of the character stream tokenizer, bound to the top level
`timescale 1ns / 1ps

module cst_checker #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEFAULT,
   parameter int LENGTH_BITS   = cst_pkg::LENGTH_BITS_DEFAULT,
   localparam int TOK_W   = cst_pkg::KIND_BITS + 2 * POSITION_BITS + LENGTH_BITS + 1,
   localparam int TDATA_W = ((TOK_W - 1 + 7) / 8) * 8,
   localparam int COL_LO  = cst_pkg::KIND_BITS + POSITION_BITS,
   localparam int LEN_LO  = cst_pkg::KIND_BITS + 2 * POSITION_BITS
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic               rsp_tlast
);

   // queue empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("token stream valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled token changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[cst_pkg::KIND_BITS-1:0] <= cst_pkg::KIND_IDENT)
      else $error("token kind out of range");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[LEN_LO +: LENGTH_BITS] != '0)
      else $error("token with zero length");

   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[cst_pkg::KIND_BITS +: POSITION_BITS] != '0)
                  && (rsp_tdata[COL_LO +: POSITION_BITS] != '0))
      else $error("token with zero line or column");

endmodule

bind char_stream_tokenizer cst_checker #(
   .POSITION_BITS (POSITION_BITS),
   .LENGTH_BITS   (LENGTH_BITS)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: verif/tb_char_stream_tokenizer.sv
// self-checking stream testbench for the character stream tokenizer
`timescale 1ns / 1ps

module tb_char_stream_tokenizer;

   localparam int POS_W       = cst_pkg::POSITION_BITS_DEFAULT;
   localparam int LEN_W       = cst_pkg::LENGTH_BITS_DEFAULT;
   localparam int KIND_W      = cst_pkg::KIND_BITS;
   localparam int CHAR_W      = cst_pkg::CHAR_BITS;
   localparam int TDATA_W     = ((KIND_W + 2 * POS_W + LEN_W + 7) / 8) * 8;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 300;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

   typedef enum logic [2:0] {LEX_IDLE, LEX_LESS, LEX_GREATER, LEX_NUMBER, LEX_WORD} lex_state_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  column;
      logic [LEN_W-1:0]  length;
      logic              last;
   } token_type;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              fin;
      bit                steady;   // no sender gap after this byte
   } source_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;  // char_byte
   logic               req_tlast  = 1'b0; // final_byte
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;  // token_kind, token_line, token_column, token_length
   logic               rsp_tlast;  // last_of_run

   source_byte_type source_bytes[$];
   token_type       expected_tokens[$];
   int              failures = 0;

   // tokenizer state mirrored by the predictor
   lex_state_type    lex_state = LEX_IDLE;
   logic [POS_W-1:0] line_now = POS_W'(1);
   logic [POS_W-1:0] column_now = POS_W'(1);
   logic [POS_W-1:0] tok_line = '0;
   logic [POS_W-1:0] tok_column = '0;
   logic [LEN_W-1:0] tok_length = '0;

   char_stream_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   function automatic token_type make_token(logic [KIND_W-1:0] kind, logic [POS_W-1:0] line,
                                            logic [POS_W-1:0] column, logic [LEN_W-1:0] length);
      token_type t;
      t.kind = kind;
      t.line = line;
      t.column = column;
      t.length = length;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic void open_run(lex_state_type next);
      lex_state = next;
      tok_line = line_now;
      tok_column = column_now;
      tok_length = LEN_W'(1);
   endfunction

   // ends the pending run, returns 1 when it makes a token
   function automatic bit close_run(output token_type t);
      logic [KIND_W-1:0] kind;
      case (lex_state)
         LEX_LESS:    kind = cst_pkg::KIND_LESS;
         LEX_GREATER: kind = cst_pkg::KIND_GREATER;
         LEX_NUMBER:  kind = cst_pkg::KIND_CONST;
         LEX_WORD:    kind = cst_pkg::KIND_IDENT;
         default: begin
            t = make_token(cst_pkg::KIND_LBRACE, '0, '0, '0);
            lex_state = LEX_IDLE;
            return 1'b0;
         end
      endcase
      t = make_token(kind, tok_line, tok_column, tok_length);
      lex_state = LEX_IDLE;
      return 1'b1;
   endfunction

   function automatic void scan_byte(logic [CHAR_W-1:0] ch, logic fin);
      token_type found[$];
      token_type t;
      bit taken, digit, letter;
      taken = 1'b0;
      digit = ch >= cst_pkg::CHAR_DIGIT_0 && ch <= cst_pkg::CHAR_DIGIT_9;
      letter = (ch >= cst_pkg::CHAR_UPPER_A && ch <= cst_pkg::CHAR_UPPER_Z) ||
               (ch >= cst_pkg::CHAR_LOWER_A && ch <= cst_pkg::CHAR_LOWER_Z);
      case (lex_state)
         LEX_LESS, LEX_GREATER: begin
            if (ch == cst_pkg::CHAR_EQUAL) begin
               t = make_token(lex_state == LEX_LESS ? cst_pkg::KIND_LESS_EQ
                                                    : cst_pkg::KIND_GREATER_EQ,
                              tok_line, tok_column, LEN_W'(2));
               found = {found, t};
               lex_state = LEX_IDLE;
               taken = 1'b1;
            end else if (close_run(t)) begin
               found = {found, t};
            end
         end
         LEX_NUMBER, LEX_WORD: begin
            if (digit || (letter && lex_state == LEX_WORD)) begin
               if (tok_length != LEN_MAX) tok_length++;
               taken = 1'b1;
            end else if (close_run(t)) begin
               found = {found, t};
            end
         end
         default: ;
      endcase
      // the byte that ends a run is scanned again as a fresh byte
      if (!taken) begin
         case (ch)
            cst_pkg::CHAR_LBRACE:
               found = {found, make_token(cst_pkg::KIND_LBRACE, line_now, column_now, LEN_W'(1))};
            cst_pkg::CHAR_RBRACE:
               found = {found, make_token(cst_pkg::KIND_RBRACE, line_now, column_now, LEN_W'(1))};
            cst_pkg::CHAR_CARET:
               found = {found, make_token(cst_pkg::KIND_CARET, line_now, column_now, LEN_W'(1))};
            cst_pkg::CHAR_PLUS:
               found = {found, make_token(cst_pkg::KIND_PLUS, line_now, column_now, LEN_W'(1))};
            cst_pkg::CHAR_MINUS:
               found = {found, make_token(cst_pkg::KIND_MINUS, line_now, column_now, LEN_W'(1))};
            cst_pkg::CHAR_LESS:    open_run(LEX_LESS);
            cst_pkg::CHAR_GREATER: open_run(LEX_GREATER);
            default: begin
               if (digit) open_run(LEX_NUMBER);
               else if (letter) open_run(LEX_WORD);
            end
         endcase
      end
      if (ch == cst_pkg::CHAR_NEWLINE) begin
         if (line_now != POS_MAX) line_now++;
         column_now = POS_W'(1);
      end else if (column_now != POS_MAX) begin
         column_now++;
      end
      if (fin && close_run(t)) found = {found, t};
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) expected_tokens = {expected_tokens, found[i]};
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void add_byte(logic [CHAR_W-1:0] ch, logic fin, bit steady);
      source_byte_type item;
      item.ch = ch;
      item.fin = fin;
      item.steady = steady;
      source_bytes = {source_bytes, item};
   endfunction

   function automatic void add_text(string s, logic fin);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], fin && i == s.len() - 1, 1'b0);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_letter();
      int r;
      r = int'($urandom_range(0, 51));
      return r < 26 ? cst_pkg::CHAR_UPPER_A + CHAR_W'(r)
                    : cst_pkg::CHAR_LOWER_A + CHAR_W'(r - 26);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_digit();
      return cst_pkg::CHAR_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_alnum();
      return $urandom_range(0, 2) == 0 ? pick_digit() : pick_letter();
   endfunction

   // sender
   bit sender_calm = 1'b0;
   always @(posedge clock) begin
      source_byte_type item;
      int gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (source_bytes.size() > 0) begin
            item = source_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.ch;
            req_tlast <= item.fin;
            if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
            gap_left = (item.steady || sender_calm) ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready, with one long hold-off so the token queue backs up into the input
   always @(posedge clock) begin
      int tokens_taken;
      int hold_left;
      int stall_left;
      bit hold_done;
      bit receiver_calm;
      if (reset) begin
         rsp_tready <= 1'b0;
         tokens_taken = 0;
         hold_left = 0;
         stall_left = 0;
         hold_done = 1'b0;
         receiver_calm = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tokens_taken++;
         if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
         if (!hold_done && tokens_taken >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= (hold_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= (stall_left == 0);
         end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: predicts on each byte transfer, checks each token transfer
   always @(posedge clock) begin
      token_type want;
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d line %0d column %0d length %0d",
                      rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[35:20], rsp_tdata[43:36]);
               $display("[char_stream_tokenizer] ERROR");
               $finish;
            end else begin
               want = expected_tokens.pop_front();
               // tdata layout: kind [3:0], line [19:4], column [35:20], length [43:36]
               check_field("token_kind", 16'(want.kind), 16'(rsp_tdata[3:0]));
               check_field("token_line", want.line, rsp_tdata[19:4]);
               check_field("token_column", want.column, rsp_tdata[35:20]);
               check_field("token_length", 16'(want.length), 16'(rsp_tdata[43:36]));
               check_field("last_of_run", 16'(want.last), 16'(rsp_tlast));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[char_stream_tokenizer] ERROR");
            $finish;
         end
      end
   end

   initial begin
      string ops[9];
      int mark;

      ops = '{"{", "}", "^", "+", "-", "<", ">", "<=", ">="};

      // directed: every kind, two tokens from one byte, high bytes, flush on the final byte
      add_text("{}^+-", 1'b0);
      add_text("<=>=", 1'b0);
      add_text("<x>9", 1'b0);
      add_byte(cst_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
      add_text("Ab1+", 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'h80, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_text("7", 1'b1);
      add_text("<", 1'b1);
      add_text(">", 1'b1);

      // random: mostly well-formed tokens, with separators, noise and broken operators
      mark = source_bytes.size();
      while (source_bytes.size() - mark < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               add_byte(pick_letter(), 1'b0, 1'b0);
               repeat ($urandom_range(0, 7)) add_byte(pick_alnum(), 1'b0, 1'b0);
            end
            2, 3: repeat ($urandom_range(1, 5)) add_byte(pick_digit(), 1'b0, 1'b0);
            4, 5: add_text(ops[$urandom_range(0, 8)], 1'b0);
            6: begin
               case ($urandom_range(0, 2))
                  0: add_byte(CHAR_SPACE, 1'b0, 1'b0);
                  1: add_byte(CHAR_TAB, 1'b0, 1'b0);
                  default: add_byte(cst_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
               endcase
            end
            7: add_byte(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            8: begin
               add_byte($urandom_range(0, 1) ? cst_pkg::CHAR_LESS : cst_pkg::CHAR_GREATER,
                        1'b0, 1'b0);
               add_byte(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            default: add_byte(CHAR_W'($urandom_range(128, 255)), 1'b0, 1'b0);
         endcase
         if ($urandom_range(0, 24) == 0) source_bytes[source_bytes.size() - 1].fin = 1'b1;
         if ($urandom_range(0, 2) == 0) add_byte(CHAR_SPACE, 1'b0, 1'b0);
      end

      // token length saturation
      add_byte(pick_letter(), 1'b0, 1'b0);
      repeat (259) add_byte(pick_alnum(), 1'b0, 1'b0);
      add_byte(CHAR_SPACE, 1'b1, 1'b0);

      // operators and runs around a newline, ending on a pending greater
      add_text("ab<=}9", 1'b0);
      add_byte(cst_pkg::CHAR_NEWLINE, 1'b0, 1'b0);
      add_text("{x", 1'b0);
      add_text("x1 {>", 1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (source_bytes.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("[char_stream_tokenizer] OK");
      end else begin
         $display("[char_stream_tokenizer] ERROR");
      end
      $finish;
   end

endmodule
